// ===== hdl/pws_pkg.sv =====
// Package with shared types and constants of the periodic write scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pws_pkg;
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_PICK   = 2'd2;
  localparam logic [1:0] KIND_STALE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [1:0] TYPE_WHOLE  = 2'd0;
  localparam logic [1:0] TYPE_TENTHS = 2'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [3:0]  entry_index;
    logic [15:0] value_tenths;
    logic        force_write;
    logic [1:0]  data_type;
    logic [31:0] period_ms;
    logic [7:0]  slot_id;
    logic [31:0] stale_after_ms;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] chosen_index;
    logic [7:0] send_byte;
    logic       blocked;
  } rsp_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [1:0]  etype;
    logic [31:0] period;
    logic [7:0]  slot;
    logic [31:0] stale_after;
    logic [15:0] value;
    logic        pending;
    logic        valid;
    logic [31:0] last_set;
    logic [31:0] last_send;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_req;   // capture request
    logic rd;         // issue RAM read at scan or set index
    logic eval;       // evaluate read data
    logic wr_create;  // write a new entry
    logic wr_update;  // write back evaluated entry
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       idx_bad;
    logic       hit;     // evaluated entry matches the request
  } sts_t;
endpackage
`default_nettype wire

// ===== hdl/pws_if.sv =====
// Valid/ready channel interface carrying one item.
`timescale 1ns / 1ps
`default_nettype none
interface pws_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pws_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [$clog2((Depth > 1) ? Depth : 2)-1:0]   addr_i,
  input  wire logic [Width-1:0]                             wdata_i,
  output logic      [Width-1:0]                             rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/pws_datapath.sv =====
// Datapath: request register, table RAM, entry evaluation and result register.
`timescale 1ns / 1ps
`default_nettype none
module pws_datapath import pws_pkg::*; #(
  parameter int MaxEntries = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  input  wire cmd_t cmd_i,
  input  wire logic [$clog2(MaxEntries+1)-1:0] scan_i,
  output sts_t      sts_o,
  output logic [$clog2(MaxEntries+1)-1:0] count_o,
  output rsp_t      rsp_o
);
  localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CW = $clog2(MaxEntries+1);

  req_t    req_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] eidx_q;
  logic [CW-1:0] rd_idx;
  entry_t  rd_ent, upd;
  logic    hit;
  logic    idx_bad;
  logic    we;
  logic [AW-1:0] addr;
  entry_t  wdata;
  logic [15:0] nv;
  logic [31:0] quot_prod;
  logic [31:0] dsend, dset;
  logic [3:0]  idx4;

  // A set value request reads the addressed entry; scans read the scan index.
  assign rd_idx = (req_q.kind == KIND_SET) ? CW'(req_q.entry_index) : scan_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.rd) eidx_q <= rd_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.wr_create) begin
      count_q <= count_q + CW'(1);
    end
  end

  assign count_o = count_q;

  always_comb begin
    // Divide by ten as a multiply by ceil(2^19 / 10) and a shift; exact for 16-bit values.
    quot_prod = 32'(req_q.value_tenths) * 32'd52429;
    nv    = (rd_ent.etype == TYPE_WHOLE) ? {3'b000, quot_prod[31:19]}
                                         : req_q.value_tenths;
    dsend = req_q.now_ms - rd_ent.last_send;
    dset  = req_q.now_ms - rd_ent.last_set;
    upd   = rd_ent;
    hit   = 1'b0;
    case (req_q.kind)
      KIND_SET: begin
        hit = (rd_ent.etype == TYPE_WHOLE) || (rd_ent.etype == TYPE_TENTHS);
        upd.pending  = rd_ent.pending | (nv != rd_ent.value) | req_q.force_write;
        upd.value    = nv;
        upd.valid    = 1'b1;
        upd.last_set = req_q.now_ms;
      end
      KIND_PICK: begin
        hit = (rd_ent.slot == req_q.slot_id) && rd_ent.valid &&
              (rd_ent.pending || ((rd_ent.period != 32'd0) &&
               ((rd_ent.last_send == 32'd0) || (dsend > rd_ent.period))));
        upd.pending   = 1'b0;
        upd.last_send = req_q.now_ms;
      end
      KIND_STALE: begin
        hit = (rd_ent.slot == req_q.slot_id) && (rd_ent.stale_after != 32'd0) &&
              (!rd_ent.valid || (dset >= rd_ent.stale_after));
      end
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    wdata = upd;
    if (cmd_i.wr_create) begin
      wdata = '0;
      wdata.etype       = req_q.data_type;
      wdata.period      = req_q.period_ms;
      wdata.slot        = req_q.slot_id;
      wdata.stale_after = req_q.stale_after_ms;
    end
  end

  assign we   = cmd_i.wr_create | cmd_i.wr_update;
  assign addr = cmd_i.wr_create ? AW'(count_q) : (cmd_i.rd ? AW'(rd_idx) : AW'(eidx_q));

  pws_ram #(.Width(EntryW), .Depth(MaxEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rd_ent)
  );

  assign idx4    = 4'(eidx_q);
  assign idx_bad = (32'(req_q.entry_index) >= 32'(count_q));
  assign sts_o.kind    = req_q.kind;
  assign sts_o.full    = (count_q >= CW'(MaxEntries));
  assign sts_o.idx_bad = idx_bad;
  assign sts_o.hit     = hit;

  // Result register: cleared when a request is captured, filled by controller commands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      rsp_o <= '0;
      case (req_i.kind)
        KIND_PICK: rsp_o.status <= ST_NONE;
        default:   rsp_o.status <= ST_OK;
      endcase
    end else if (cmd_i.wr_create) begin
      rsp_o.chosen_index <= 4'(count_q);
    end else if (cmd_i.eval) begin
      case (req_q.kind)
        KIND_CREATE: rsp_o.status <= ST_FULL;
        KIND_SET: begin
          if (hit && !idx_bad) rsp_o.chosen_index <= idx4;
          else rsp_o.status <= ST_IGNORED;
        end
        KIND_PICK: if (hit) begin
          rsp_o.status       <= ST_OK;
          rsp_o.chosen_index <= idx4;
          rsp_o.send_byte    <= (rd_ent.value > 16'd255) ? 8'hFF : rd_ent.value[7:0];
        end
        KIND_STALE: if (hit) rsp_o.blocked <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/pws_ctrl.sv =====
// Controller state machine sequencing the table scan.
`timescale 1ns / 1ps
`default_nettype none
module pws_ctrl import pws_pkg::*; #(
  parameter int MaxEntries = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  input  wire logic [$clog2(MaxEntries+1)-1:0] count_i,
  output cmd_t      cmd_o,
  output logic [$clog2(MaxEntries+1)-1:0] scan_o
);
  localparam int CW = $clog2(MaxEntries+1);
  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_READ, S_WAIT, S_EVAL, S_DONE} state_e;

  state_e state_q, state_d;
  logic [CW-1:0] scan_q, scan_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] kind;

  assign kind = sts_i.kind;
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign scan_o = scan_q;

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    out_valid_d = out_valid_q;
    cmd_o   = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        cmd_o.load_req = 1'b1;
        state_d = S_DECODE;
      end
      S_DECODE: begin
        case (kind)
          KIND_CREATE: begin
            if (!sts_i.full) cmd_o.wr_create = 1'b1;
            else cmd_o.eval = 1'b1;
            state_d = S_DONE;
          end
          KIND_SET: begin
            if (sts_i.idx_bad) begin
              cmd_o.eval = 1'b1;
              state_d = S_DONE;
            end else begin
              scan_d = '0;
              state_d = S_READ;
            end
          end
          default: begin
            scan_d = '0;
            state_d = (count_i == '0) ? S_DONE : S_READ;
          end
        endcase
      end
      S_READ: begin
        state_d = S_WAIT;
      end
      S_WAIT: state_d = S_EVAL;
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (kind == KIND_SET) begin
          if (sts_i.hit) cmd_o.wr_update = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.hit) begin
          if (kind == KIND_PICK) cmd_o.wr_update = 1'b1;
          state_d = S_DONE;
        end else if (scan_q + CW'(1) >= count_i) begin
          state_d = S_DONE;
        end else begin
          scan_d = scan_q + CW'(1);
          state_d = S_READ;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_READ) cmd_o.rd = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/periodic_write_scheduler_top.sv =====
// Top level of the periodic write scheduler.
//
// Usage: requests arrive as items on req (valid/ready), one result item per
// request leaves on rsp. A request kind creates a table entry, sets an entry
// value, picks the next entry of a slot to be written, or asks whether a slot
// is blocked by a stale entry.
// The table lives in one single-port RAM; entries are read one per scan
// step, and each step issues the address, waits for the registered read and evaluates.
// A create request goes from decode straight to the result; a set value request
// reads its one entry, unless it is ignored at decode for a bad index; a pick or
// stale query scans the entries in order until one matches, reading at most
// as many entries as have been created (up to MAX_ENTRIES).
// One request is handled at a time; a new request is taken only once the
// previous result item has been taken by the receiver, at the earliest in the
// cycle after that. While the receiver stalls, the result item holds and req stays
// not ready.
// Reset clears the entry count and the control state; the table contents
// need no clearing because only created entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module periodic_write_scheduler_top import pws_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pws_if.sink      req,
  pws_if.source    rsp
);
  localparam int CW = $clog2(MAX_ENTRIES+1);

  cmd_t cmd;
  sts_t sts;
  logic [CW-1:0] scan, count;

  // The controller only sequences; request, table and result storage sit in the datapath.
  pws_ctrl #(.MaxEntries(MAX_ENTRIES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .sts_i      (sts),
    .count_i    (count),
    .cmd_o      (cmd),
    .scan_o     (scan)
  );

  pws_datapath #(.MaxEntries(MAX_ENTRIES)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req.data),
    .cmd_i  (cmd),
    .scan_i (scan),
    .sts_o  (sts),
    .count_o(count),
    .rsp_o  (rsp.data)
  );
endmodule
`default_nettype wire
